FILE: sv/cpsp_pkg.sv
// ----------------------------------------------------------------------------
// cpsp_pkg
// Shared constants for the circle pair separation projection pipeline.
// ----------------------------------------------------------------------------
package cpsp_pkg;

  // default coordinate width (signed fixed point, raw integer arithmetic)
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // root bits resolved per square root pipeline stage
  localparam int unsigned SQRT_STEPS = 4;

  // quotient bits resolved per divider pipeline stage
  localparam int unsigned DIV_STEPS = 4;

endpackage

FILE: sv/circle_pair_separation_projection.sv
// ----------------------------------------------------------------------------
// circle_pair_separation_projection
// Pushes two overlapping circles apart along their center line, one pair a clock.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  item in  | start_i, busy_o     | first_x/y_i, second_x/y_i, radius_sum_i
//  item out | valid_o (strobe)    | new_first_x/y_o, new_second_x/y_o,
//           |                     | weight_standard_o
//
//  One item is taken every clock; busy_o is never raised.
//  Each item runs through the square root pipe (4 root bits a stage) and
//  then through the two dividers (4 quotient bits a stage).
//  Reset clears only the valid bits; data registers are not reset.
//  The receiver cannot stall: each result is shown on valid_o for one clock.
// ----------------------------------------------------------------------------
module circle_pair_separation_projection #(
  parameter int unsigned COORD_WIDTH = cpsp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic        [COORD_WIDTH-2:0] radius_sum_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] new_first_x_o,
  output logic signed [COORD_WIDTH-1:0] new_first_y_o,
  output logic signed [COORD_WIDTH-1:0] new_second_x_o,
  output logic signed [COORD_WIDTH-1:0] new_second_y_o,
  output logic                          weight_standard_o
);
  import cpsp_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned AW   = CW + 1;           // |dx|, |dy|, distance
  localparam int unsigned SW   = 2 * CW + 2;       // dx^2 + dy^2
  localparam int unsigned QW   = CW - 1;           // push magnitude
  localparam int unsigned DW   = CW + 2;           // divisor 2*d
  localparam int unsigned NSQ  = (AW + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int unsigned NDV  = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned LAT  = 7 + NSQ + NDV;
  localparam int unsigned S1W  = 4 * CW + (CW - 1) + 2 * AW + 2;
  localparam int unsigned S2W  = 4 * CW + 3;
  localparam int unsigned L1   = 2 + NSQ;          // side line depth to sqrt output
  localparam int unsigned L2   = 2 + NDV;          // side line depth to divider output

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---- stage 1: differences and magnitudes --------------------------------
  logic signed [CW:0] dx, dy;
  logic [AW-1:0]      ax, ay;

  assign dx = {second_x_i[CW-1], second_x_i} - {first_x_i[CW-1], first_x_i};
  assign dy = {second_y_i[CW-1], second_y_i} - {first_y_i[CW-1], first_y_i};
  assign ax = dx[CW] ? AW'(-dx) : AW'(dx);
  assign ay = dy[CW] ? AW'(-dy) : AW'(dy);

  // side payload: {x1, y1, x2, y2, rs, ax, ay, sdx, sdy}
  logic [S1W-1:0] side1_q [L1+1];
  logic           v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i) begin
    side1_q[0] <= {first_x_i, first_y_i, second_x_i, second_y_i, radius_sum_i,
                   ax, ay, dx[CW], dy[CW]};
    for (int i = 0; i < int'(L1); i++) begin
      side1_q[i+1] <= side1_q[i];
    end
  end

  logic [CW-1:0] s1_x1, s1_y1, s1_x2, s1_y2;
  logic [CW-2:0] s1_rs;
  logic [AW-1:0] s1_ax, s1_ay;
  logic          s1_sdx, s1_sdy;

  assign {s1_x1, s1_y1, s1_x2, s1_y2, s1_rs, s1_ax, s1_ay, s1_sdx, s1_sdy} = side1_q[0];

  // ---- stage 2: squares ---------------------------------------------------
  logic [2*AW-1:0] sqx_q, sqy_q;
  logic [SW-1:0]   sum_q;

  always_ff @(posedge clk_i) begin
    sqx_q <= s1_ax * s1_ax;
    sqy_q <= s1_ay * s1_ay;
    sum_q <= SW'(sqx_q) + SW'(sqy_q);   // stage 3
  end

  // ---- square root pipe ---------------------------------------------------
  logic          sq_vld;
  logic [AW-1:0] cdist;

  cpsp_sqrt #(
    .OW (AW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (sum_q),
    .valid_o (sq_vld),
    .root_o  (cdist)
  );

  logic [CW-1:0] d_x1, d_y1, d_x2, d_y2;
  logic [CW-2:0] d_rs;
  logic [AW-1:0] d_ax, d_ay;
  logic          d_sdx, d_sdy;

  assign {d_x1, d_y1, d_x2, d_y2, d_rs, d_ax, d_ay, d_sdx, d_sdy} = side1_q[L1];

  // ---- stage 4: overlap test, coincident centers fall back to (1,0) --------
  logic          overlap, coinc;
  logic [QW-1:0] ov_d;

  assign overlap = cdist <= AW'(d_rs);
  assign coinc   = cdist == '0;
  assign ov_d    = overlap ? d_rs - cdist[QW-1:0] : '0;   // no overlap: push of zero

  logic [QW-1:0]  ov4_q;
  logic [AW-1:0]  axe4_q, aye4_q, dd4_q, dd5_q;
  logic [S2W-1:0] side2_q [L2+1];
  logic           v4_q, v5_q, v6_q;

  always_ff @(posedge clk_i) begin
    ov4_q      <= ov_d;
    axe4_q     <= coinc ? AW'(1) : d_ax;
    aye4_q     <= coinc ? '0 : d_ay;
    dd4_q      <= coinc ? AW'(1) : cdist;
    side2_q[0] <= {d_x1, d_y1, d_x2, d_y2, d_sdx, d_sdy, overlap};
    for (int i = 0; i < int'(L2); i++) begin
      side2_q[i+1] <= side2_q[i];
    end
  end

  // ---- stage 5: ov * |component| ------------------------------------------
  logic [QW+AW-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    px_q  <= ov4_q * axe4_q;
    py_q  <= ov4_q * aye4_q;
    dd5_q <= dd4_q;
  end

  // ---- stage 6: add d for round half up, divisor 2d ------------------------
  logic [DW+QW-1:0] nx_q, ny_q;
  logic [DW-1:0]    den_q;

  always_ff @(posedge clk_i) begin
    nx_q  <= (DW+QW)'(px_q) + (DW+QW)'(dd5_q);
    ny_q  <= (DW+QW)'(py_q) + (DW+QW)'(dd5_q);
    den_q <= {dd5_q, 1'b0};
  end

  // ---- dividers -----------------------------------------------------------
  logic          dvx_vld, dvy_vld;
  logic [QW-1:0] mxa, mya;

  cpsp_div #(
    .QW (QW),
    .DW (DW)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .num_i   (nx_q),
    .den_i   (den_q),
    .valid_o (dvx_vld),
    .quo_o   (mxa)
  );

  cpsp_div #(
    .QW (QW),
    .DW (DW)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .num_i   (ny_q),
    .den_i   (den_q),
    .valid_o (dvy_vld),
    .quo_o   (mya)
  );

  // ---- output stage: apply signs, move centers, saturate -------------------
  logic [CW-1:0] o_x1, o_y1, o_x2, o_y2;
  logic          o_sdx, o_sdy, o_w;

  assign {o_x1, o_y1, o_x2, o_y2, o_sdx, o_sdy, o_w} = side2_q[L2];

  logic signed [CW+1:0] mx, my, rx1, ry1, rx2, ry2;

  assign mx  = o_sdx ? -$signed({3'b000, mxa}) : $signed({3'b000, mxa});
  assign my  = o_sdy ? -$signed({3'b000, mya}) : $signed({3'b000, mya});
  assign rx1 = $signed({{2{o_x1[CW-1]}}, o_x1}) - mx;
  assign ry1 = $signed({{2{o_y1[CW-1]}}, o_y1}) - my;
  assign rx2 = $signed({{2{o_x2[CW-1]}}, o_x2}) + mx;
  assign ry2 = $signed({{2{o_y2[CW-1]}}, o_y2}) + my;

  function automatic logic [CW-1:0] sat(input logic [CW+1:0] v);
    logic [CW-1:0] r;
    if (v[CW+1:CW-1] == '0 || v[CW+1:CW-1] == '1) begin
      r = v[CW-1:0];
    end else begin
      r = v[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  logic vo_q;

  always_ff @(posedge clk_i) begin
    new_first_x_o     <= sat(rx1);
    new_first_y_o     <= sat(ry1);
    new_second_x_o    <= sat(rx2);
    new_second_y_o    <= sat(ry2);
    weight_standard_o <= o_w;
  end

  // ---- valid chain ---------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= sq_vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= dvx_vld;
    end
  end

  assign valid_o = vo_q;

`ifndef ASSERT_OFF
  a_div_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx_vld == dvy_vld)
    else $error("divider valids out of step");

  a_result_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT))
    else $error("result without an item");

  a_item_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("item lost in pipeline");

  a_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("pipeline raised busy");
`endif

endmodule

FILE: sv/cpsp_sqrt.sv
// ----------------------------------------------------------------------------
// cpsp_sqrt
// Pipelined integer square root, floor(sqrt(rad)), several root bits a stage.
// ----------------------------------------------------------------------------
module cpsp_sqrt #(
  parameter int unsigned OW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*OW-1:0] rad_i,
  output logic            valid_o,
  output logic [OW-1:0]   root_o
);
  import cpsp_pkg::*;

  localparam int unsigned TW  = 2 * OW + 1;
  localparam int unsigned NST = (OW + SQRT_STEPS - 1) / SQRT_STEPS;

  logic [TW-1:0] rem_p  [NST];
  logic [OW-1:0] root_p [NST+1];
  logic          vld_q  [NST+1];

  assign rem_p[0]  = {1'b0, rad_i};
  assign root_p[0] = '0;
  assign vld_q[0]  = valid_i;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [TW-1:0] rem_d;
    logic [OW-1:0] root_d;

    always_comb begin
      logic [TW-1:0] trial;
      int            b;
      rem_d  = rem_p[s];
      root_d = root_p[s];
      trial  = '0;
      for (int k = 0; k < int'(SQRT_STEPS); k++) begin
        b = int'(OW) - 1 - s * int'(SQRT_STEPS) - k;
        if (b >= 0) begin
          // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
          trial = (TW'(root_d) << (b + 1)) + (TW'(1) << (2 * b));
          if (trial <= rem_d) begin
            rem_d  = rem_d - trial;
            root_d = root_d | (OW'(1) << b);
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      root_p[s+1] <= root_d;
    end

    if (s < NST - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_p[s+1] <= rem_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  assign valid_o = vld_q[NST];
  assign root_o  = root_p[NST];

endmodule

FILE: sv/cpsp_div.sv
// ----------------------------------------------------------------------------
// cpsp_div
// Pipelined restoring divider; the quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module cpsp_div #(
  parameter int unsigned QW = 31,
  parameter int unsigned DW = 34
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [DW+QW-1:0]   num_i,
  input  logic [DW-1:0]      den_i,
  output logic               valid_o,
  output logic [QW-1:0]      quo_o
);
  import cpsp_pkg::*;

  localparam int unsigned NST = (QW + DIV_STEPS - 1) / DIV_STEPS;

  logic [DW-1:0] rem_p [NST];
  logic [DW-1:0] den_p [NST];
  logic [QW-1:0] low_p [NST+1];   // numerator bits still to shift in, quotient fills from bottom
  logic          vld_q [NST+1];

  assign rem_p[0] = num_i[DW+QW-1:QW];
  assign low_p[0] = num_i[QW-1:0];
  assign den_p[0] = den_i;
  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [DW-1:0] rem_d;
    logic [QW-1:0] low_d;

    always_comb begin
      logic [DW:0] r2;
      int          idx;
      rem_d = rem_p[s];
      low_d = low_p[s];
      r2    = '0;
      for (int k = 0; k < int'(DIV_STEPS); k++) begin
        idx = s * int'(DIV_STEPS) + k;
        if (idx < int'(QW)) begin
          r2    = {rem_d, low_d[QW-1]};
          low_d = low_d << 1;
          if (r2 >= {1'b0, den_p[s]}) begin
            r2       = r2 - {1'b0, den_p[s]};
            low_d[0] = 1'b1;
          end
          rem_d = r2[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      low_p[s+1] <= low_d;
    end

    if (s < NST - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_p[s+1] <= rem_d;
        den_p[s+1] <= den_p[s];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  assign valid_o = vld_q[NST];
  assign quo_o   = low_p[NST];

endmodule

FILE: verif/tb_circle_pair_separation_projection.sv
// ----------------------------------------------------------------------------
// tb_circle_pair_separation_projection
// Self-checking bench: directed pair table, then random pairs, each result
// compared field by field against an in-bench projection predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_circle_pair_separation_projection;

  localparam int unsigned CW = cpsp_pkg::COORD_WIDTH_DEF;
  localparam int unsigned LATENCY = 7 + (CW + 1 + 3) / 4 + (CW - 1 + 3) / 4;
  localparam int unsigned N_RANDOM = 930;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-2:0] rsum_t;

  typedef struct packed {
    coord_t x1, y1, x2, y2;
    rsum_t  rs;
  } pair_t;

  typedef struct packed {
    coord_t nx1, ny1, nx2, ny2;
    logic   weight;
  } proj_t;

  // directed row: known result typed in where obvious
  typedef struct packed {
    pair_t pair;
    logic  has_known;
    proj_t known;
  } row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   busy_o;
  coord_t first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  rsum_t  radius_sum_i = '0;
  logic   valid_o;
  coord_t new_first_x_o, new_first_y_o, new_second_x_o, new_second_y_o;
  logic   weight_standard_o;

  proj_t  pending_proj_q[$];
  int     mismatch_cnt = 0;
  int     result_cnt = 0;
  int     overlap_cnt = 0;
  int     apart_cnt = 0;

  circle_pair_separation_projection dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i, .radius_sum_i,
    .valid_o, .new_first_x_o, .new_first_y_o, .new_second_x_o,
    .new_second_y_o, .weight_standard_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // integer square root, floor, over a 128-bit radicand
  function automatic logic [63:0] isqrt128(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic coord_t clamp_coord(logic signed [CW+1:0] v);
    logic signed [CW+1:0] top;
    logic signed [CW+1:0] bot;
    top = (CW+2)'((64'sd1 <<< (CW - 1)) - 1);
    bot = -top - 1;
    if (v > top) return coord_t'(top);
    if (v < bot) return coord_t'(bot);
    return coord_t'(v);
  endfunction

  // expected projection of one circle pair
  function automatic proj_t project_pair(pair_t p);
    logic signed [CW+1:0] dx, dy, mx, my;
    logic [CW:0]   ax, ay;
    logic [127:0]  sq;
    logic [63:0]   cdist, ov, mxa, mya;
    logic [127:0]  num;
    proj_t r;
    dx = (CW+2)'(p.x2) - (CW+2)'(p.x1);
    dy = (CW+2)'(p.y2) - (CW+2)'(p.y1);
    ax = dx < 0 ? (CW+1)'(-dx) : (CW+1)'(dx);
    ay = dy < 0 ? (CW+1)'(-dy) : (CW+1)'(dy);
    sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    cdist = isqrt128(sq);
    mx = '0;
    my = '0;
    r.weight = 1'b0;
    if (cdist <= 64'(p.rs)) begin
      ov = 64'(p.rs) - cdist;
      if (cdist == 64'd0) begin
        ax = (CW+1)'(1);
        ay = '0;
        cdist = 64'd1;
      end
      num = 128'(ov) * 128'(ax) + 128'(cdist);
      mxa = 64'(num / (128'(cdist) << 1));
      num = 128'(ov) * 128'(ay) + 128'(cdist);
      mya = 64'(num / (128'(cdist) << 1));
      mx = dx < 0 ? -(CW+2)'(mxa) : (CW+2)'(mxa);
      my = dy < 0 ? -(CW+2)'(mya) : (CW+2)'(mya);
      r.weight = 1'b1;
    end
    r.nx1 = clamp_coord((CW+2)'(p.x1) - mx);
    r.ny1 = clamp_coord((CW+2)'(p.y1) - my);
    r.nx2 = clamp_coord((CW+2)'(p.x2) + mx);
    r.ny2 = clamp_coord((CW+2)'(p.y2) + my);
    return r;
  endfunction

  // often no gap, otherwise a short one, a long one now and then
  task automatic idle_gap();
    int n;
    n = 0;
    if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 3);
    if ($urandom_range(0, 40) == 0) n = $urandom_range(10, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold one pair on the ports until taken; start stays up for a next item
  task automatic send_pair(pair_t p);
    start_i      <= 1'b1;
    first_x_i    <= p.x1;
    first_y_i    <= p.y1;
    second_x_i   <= p.x2;
    second_y_i   <= p.y2;
    radius_sum_i <= p.rs;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_proj_q.insert(pending_proj_q.size(), project_pair(p));
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return coord_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  // mostly nearby pairs so overlap is common; some wide-range noise
  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    logic [63:0] d;
    mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
    p.x1 = rand_coord(mode);
    p.y1 = rand_coord(mode);
    if ($urandom_range(0, 3) == 0) begin
      p.x2 = p.x1 + coord_t'($signed($urandom_range(0, 64)) - 32);
      p.y2 = p.y1 + coord_t'($signed($urandom_range(0, 64)) - 32);
    end else begin
      p.x2 = rand_coord(mode);
      p.y2 = rand_coord(mode);
    end
    case ($urandom_range(0, 3))
      0: p.rs = rsum_t'($urandom);
      1: p.rs = rsum_t'($urandom_range(0, 4000));
      default: begin
        // radius sum near the true distance, touching case included
        d = isqrt128(128'(($signed(p.x2) - $signed(p.x1)) ** 2)
                   + 128'(($signed(p.y2) - $signed(p.y1)) ** 2));
        p.rs = rsum_t'(d + $urandom_range(0, 8000) - 2000);
      end
    endcase
    return p;
  endfunction

  // result monitor: no backpressure possible, sample at each edge
  always @(posedge clk_i) begin
    proj_t exp_r;
    proj_t got;
    if (rst_ni && valid_o) begin
      got = '{nx1: new_first_x_o, ny1: new_first_y_o, nx2: new_second_x_o,
              ny2: new_second_y_o, weight: weight_standard_o};
      result_cnt++;
      if (pending_proj_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = pending_proj_q.pop_front();
        if (exp_r.weight) overlap_cnt++; else apart_cnt++;
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp %p got %p", exp_r, got);
        end
      end
    end
  end

  localparam coord_t CMAX = coord_t'({1'b0, {(CW-1){1'b1}}});
  localparam coord_t CMIN = coord_t'({1'b1, {(CW-1){1'b0}}});
  localparam rsum_t  RMAX = '1;

  row_t dir_tbl[] = '{
    // coincident centers, zero radius: touching, unchanged, standard weight
    '{'{0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b1}},
    // coincident centers push along +x: (5+1)>>1 = 3
    '{'{0, 0, 0, 0, 5}, 1'b1, '{-3, 0, 3, 0, 1'b1}},
    // far apart, no overlap
    '{'{0, 0, 100, 0, 10}, 1'b1, '{0, 0, 100, 0, 1'b0}},
    // exactly touching 3-4-5
    '{'{0, 0, 3, 4, 5}, 1'b1, '{0, 0, 3, 4, 1'b1}},
    '{'{0, 0, 3, 4, 15}, 1'b0, '0},
    '{'{10, 10, 7, 6, 9}, 1'b0, '0},
    '{'{-5, 7, -5, -9, 40}, 1'b0, '0},
    // extremes
    '{'{CMAX, CMAX, CMAX, CMAX, RMAX}, 1'b1, '{CMAX - ((RMAX + 1) >> 1) + 0,
       CMAX, CMAX, CMAX, 1'b1}},
    '{'{CMIN, CMIN, CMIN, CMIN, RMAX}, 1'b0, '0},
    '{'{CMIN, CMIN, CMAX, CMAX, RMAX}, 1'b1, '{CMIN, CMIN, CMAX, CMAX, 1'b0}},
    '{'{CMAX, 0, CMIN, 0, RMAX}, 1'b1, '{CMAX, 0, CMIN, 0, 1'b0}},
    '{'{CMIN, CMAX, CMIN, CMAX, 0}, 1'b1, '{CMIN, CMAX, CMIN, CMAX, 1'b1}},
    '{'{0, 0, 1, 0, RMAX}, 1'b0, '0},
    '{'{-1, -1, -1, -1, RMAX}, 1'b0, '0},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
        31'h2AAA_AAAA}, 1'b0, '0},
    '{'{0, 0, 1, 1, 2}, 1'b0, '0},
    '{'{0, 0, -1, -1, 3}, 1'b0, '0}
  };

  initial begin
    proj_t chk;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].has_known) begin
        chk = project_pair(dir_tbl[i].pair);
        // a typed row that disagrees with the predictor is a bench error
        if (chk !== dir_tbl[i].known) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("table row %0d: typed %p predicted %p", i,
                     dir_tbl[i].known, chk);
        end
      end
      send_pair(dir_tbl[i].pair);
      if (i % 4 == 3) idle_gap();
    end

    // drain once fully before the random phase
    start_i <= 1'b0;
    while (pending_proj_q.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      send_pair(rand_pair());
      if (n < 300 || n > 600) idle_gap();
      if (n == 450) begin
        start_i <= 1'b0;
        while (pending_proj_q.size() != 0) @(posedge clk_i);
      end
    end

    start_i <= 1'b0;
    while (pending_proj_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("Checked %0d results: %0d overlapping pairs, %0d apart pairs.",
             result_cnt, overlap_cnt, apart_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Timeout");
    $display("Verification failed");
    $finish;
  end

endmodule
